// ----- src/two_level_inclusive_cache_lru_defines.svh -----
// Assertion macros for the two-level inclusive cache.
`ifndef TWO_LEVEL_INCLUSIVE_CACHE_LRU_DEFINES_SVH
`define TWO_LEVEL_INCLUSIVE_CACHE_LRU_DEFINES_SVH
`ifndef SYNTHESIS
`define CLRU_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("cache check failed");
`define CLRU_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("cache check failed");
`else
`define CLRU_ASSERT_IMP(lbl, a, c)
`define CLRU_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ----- src/clru_pkg.sv -----
// Shared types and constants of the two-level inclusive cache.
package clru_pkg;

  localparam int RANK_W = 3;
  localparam int WAY_W  = 3;

  localparam logic [1:0] LVL_L1  = 2'd0;
  localparam logic [1:0] LVL_L2  = 2'd1;
  localparam logic [1:0] LVL_MEM = 2'd2;

  localparam logic [2:0] CFG_WRITE_ALLOCATE = 3'd0;
  localparam logic [2:0] CFG_L1_SETS_LOG2   = 3'd1;
  localparam logic [2:0] CFG_L1_WAYS_LOG2   = 3'd2;
  localparam logic [2:0] CFG_L2_SETS_LOG2   = 3'd3;
  localparam logic [2:0] CFG_L2_WAYS_LOG2   = 3'd4;
  localparam logic [2:0] CFG_L1_LATENCY     = 3'd5;
  localparam logic [2:0] CFG_L2_LATENCY     = 3'd6;
  localparam logic [2:0] CFG_MEM_LATENCY    = 3'd7;

  typedef enum logic [1:0] {
    SW_SCAN  = 2'd0,
    SW_TOUCH = 2'd1,
    SW_DROP  = 2'd2,
    SW_FILL  = 2'd3
  } sw_mode_t;

  typedef struct packed {
    sw_mode_t            mode;
    logic                l2;
    logic [1:0]          ways_log2;
    logic [WAY_W-1:0]    way;
    logic [RANK_W-1:0]   rank;
    logic                flag;
  } sw_cmd_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [RANK_W-1:0]   hit_rank;
    logic                full;
    logic [WAY_W-1:0]    slot;
    logic                vic_dirty;
    logic [RANK_W-1:0]   vic_rank;
  } sw_scan_t;

endpackage

// ----- src/clru_sweep.sv -----
// Tag stores of both levels and the unit that walks one set a way per cycle.
module clru_sweep import clru_pkg::*; #(
  parameter int BW       = 27,
  parameter int L1_LINES = 256,
  parameter int L2_LINES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_start,
  output logic          clearing,
  input  logic          start,
  input  sw_cmd_t       cmd,
  input  logic [((L1_LINES > L2_LINES ? L1_LINES : L2_LINES) > 1 ?
                 $clog2(L1_LINES > L2_LINES ? L1_LINES : L2_LINES) : 1)-1:0] base,
  input  logic [BW-1:0] blk,
  output logic          done,
  output sw_scan_t      scan,
  output logic [BW-1:0] vic_blk
);

  localparam int CD  = L1_LINES > L2_LINES ? L1_LINES : L2_LINES;
  localparam int LW  = CD > 1 ? $clog2(CD) : 1;
  localparam int A1W = L1_LINES > 1 ? $clog2(L1_LINES) : 1;
  localparam int A2W = L2_LINES > 1 ? $clog2(L2_LINES) : 1;
  localparam int EW  = BW + RANK_W + 2;

  logic [EW-1:0] l1_mem [L1_LINES];
  logic [EW-1:0] l2_mem [L2_LINES];
  logic [EW-1:0] rd1_r, rd2_r;

  logic              clr_r;
  logic [LW-1:0]     ccnt_r;
  logic              iss_r, pend_r, done_r;
  logic [WAY_W-1:0]  cnt_r, pway_r;
  logic [LW-1:0]     wa_r, base_r;
  sw_cmd_t           cmd_r;
  logic [BW-1:0]     blk_r;

  logic              hit_r, inv_r, lru_r;
  logic [WAY_W-1:0]  hway_r, iway_r, lway_r;
  logic [RANK_W-1:0] hrank_r, lrank_r, w0rank_r;
  logic              ldirty_r, w0dirty_r;
  logic [BW-1:0]     lblk_r, w0blk_r;

  logic [LW-1:0]     raddr;
  logic [WAY_W-1:0]  last_way;
  logic [EW-1:0]     d, wd, mwd;
  logic              dv, dd, nv, nd, is_t;
  logic [RANK_W-1:0] dr, nr;
  logic [BW-1:0]     db, nb;
  logic              we1, we2, sw_we;
  logic [A1W-1:0]    wa1;
  logic [A2W-1:0]    wa2;

  assign raddr    = base_r | LW'(cnt_r);
  assign last_way = ~({WAY_W{1'b1}} << cmd_r.ways_log2);

  always_comb begin
    d    = cmd_r.l2 ? rd2_r : rd1_r;
    dv   = d[EW-1];
    dd   = d[EW-2];
    dr   = d[EW-3 -: RANK_W];
    db   = d[BW-1:0];
    is_t = (pway_r == cmd_r.way);
    nv   = dv;
    nd   = dd;
    nr   = dr;
    nb   = db;
    case (cmd_r.mode)
      SW_TOUCH: begin
        if (is_t) begin
          nr = '0;
          nd = dd | cmd_r.flag;
        end else if (dv && dr < cmd_r.rank) begin
          nr = dr + RANK_W'(1);
        end
      end
      SW_DROP: begin
        if (is_t) begin
          nv = 1'b0;
        end else if (dv && dr > cmd_r.rank) begin
          nr = dr - RANK_W'(1);
        end
      end
      SW_FILL: begin
        if (is_t) begin
          nv = 1'b1;
          nd = cmd_r.flag;
          nr = '0;
          nb = blk_r;
        end else if (dv) begin
          nr = dr + RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
    wd = {nv, nd, nr, nb};
  end

  assign sw_we = pend_r && (cmd_r.mode != SW_SCAN);
  assign we1   = clr_r ? ({1'b0, ccnt_r} < (LW+1)'(L1_LINES)) : (sw_we && !cmd_r.l2);
  assign we2   = clr_r ? ({1'b0, ccnt_r} < (LW+1)'(L2_LINES)) : (sw_we && cmd_r.l2);
  assign wa1   = clr_r ? ccnt_r[A1W-1:0] : wa_r[A1W-1:0];
  assign wa2   = clr_r ? ccnt_r[A2W-1:0] : wa_r[A2W-1:0];
  assign mwd   = clr_r ? '0 : wd;

  always_ff @(posedge clk) begin
    if (we1) begin
      l1_mem[wa1] <= mwd;
    end
    rd1_r <= l1_mem[raddr[A1W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we2) begin
      l2_mem[wa2] <= mwd;
    end
    rd2_r <= l2_mem[raddr[A2W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= 1'b1;
      ccnt_r <= '0;
    end else if (clr_start) begin
      clr_r  <= 1'b1;
      ccnt_r <= '0;
    end else if (clr_r) begin
      ccnt_r <= ccnt_r + LW'(1);
      if (ccnt_r == LW'(CD - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && pend_r && (pway_r == last_way);
      if (start) begin
        iss_r  <= 1'b1;
        pend_r <= 1'b0;
        cnt_r  <= '0;
        cmd_r  <= cmd;
        base_r <= base;
        blk_r  <= blk;
        hit_r  <= 1'b0;
        inv_r  <= 1'b0;
        lru_r  <= 1'b0;
      end else begin
        pend_r <= iss_r;
        if (iss_r) begin
          pway_r <= cnt_r;
          wa_r   <= raddr;
          cnt_r  <= cnt_r + WAY_W'(1);
          if (cnt_r == last_way) begin
            iss_r <= 1'b0;
          end
        end
        if (pend_r) begin
          if (dv && db == blk_r && !hit_r) begin
            hit_r   <= 1'b1;
            hway_r  <= pway_r;
            hrank_r <= dr;
          end
          if (!dv && !inv_r) begin
            inv_r  <= 1'b1;
            iway_r <= pway_r;
          end
          if (dr == last_way && !lru_r) begin
            lru_r    <= 1'b1;
            lway_r   <= pway_r;
            lblk_r   <= db;
            ldirty_r <= dd;
            lrank_r  <= dr;
          end
          if (pway_r == '0) begin
            w0blk_r   <= db;
            w0dirty_r <= dd;
            w0rank_r  <= dr;
          end
        end
      end
    end
  end

  always_comb begin
    scan.hit       = hit_r;
    scan.hit_way   = hway_r;
    scan.hit_rank  = hrank_r;
    scan.full      = !inv_r;
    scan.slot      = inv_r ? iway_r : (lru_r ? lway_r : '0);
    scan.vic_dirty = lru_r ? ldirty_r : w0dirty_r;
    scan.vic_rank  = lru_r ? lrank_r : w0rank_r;
    vic_blk        = lru_r ? lblk_r : w0blk_r;
  end

  assign done     = done_r;
  assign clearing = clr_r;

endmodule

// ----- src/two_level_inclusive_cache_lru.sv -----
// Two-level inclusive set-associative cache model with true LRU and back-invalidation.
// One access is taken at a time and its result appears after a sequence of set walks:
// each walk reads one way per cycle through the tag-store port and, but in a scan,
// rewrites it; an L1 hit needs two walks and then loads the result register in S_OUT,
// a miss with fills and evictions up to ten walks. After reset, and after any write to a
// set or way register, both stores are cleared one line per cycle until every line of
// each store is zero, while no access is taken.
`include "two_level_inclusive_cache_lru_defines.svh"
module two_level_inclusive_cache_lru import clru_pkg::*; #(
  parameter int BLOCK_OFFSET_BITS = 5,
  parameter int ADDR_BITS         = 32,
  parameter int L1_LINES          = 256,
  parameter int L2_LINES          = 4096,
  parameter int MAX_WAYS          = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_hit_level,
  output logic [11:0] out_access_cycles,
  output logic        out_back_invalidated,
  output logic        out_l1_victim_dirty,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int AW   = ADDR_BITS < 32 ? ADDR_BITS : 32;
  localparam int BW   = AW - BLOCK_OFFSET_BITS;
  localparam int CD   = L1_LINES > L2_LINES ? L1_LINES : L2_LINES;
  localparam int LW   = CD > 1 ? $clog2(CD) : 1;
  localparam int L1CL = $clog2(L1_LINES + 1) - 1;
  localparam int L2CL = $clog2(L2_LINES + 1) - 1;
  localparam int MWL  = $clog2(MAX_WAYS + 1) - 1;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_L1_SCAN  = 14'b00000000000010,
    S_L1_TOUCH = 14'b00000000000100,
    S_L2_SCAN  = 14'b00000000001000,
    S_L2_TOUCH = 14'b00000000010000,
    S_L1_DROP  = 14'b00000000100000,
    S_L1_FILL  = 14'b00000001000000,
    S_L2_DROP  = 14'b00000010000000,
    S_L2_FILL  = 14'b00000100000000,
    S_WB_SCAN  = 14'b00001000000000,
    S_WB_TOUCH = 14'b00010000000000,
    S_BI_SCAN  = 14'b00100000000000,
    S_BI_DROP  = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  logic       wa_en_r;
  logic [3:0] l1_sets_r, l2_sets_r;
  logic [1:0] l1_ways_r, l2_ways_r;
  logic [9:0] l1_lat_r, l2_lat_r, mem_lat_r;

  state_t            state_r, state_nxt;
  logic              wait_r;
  logic              wr_r;
  logic [BW-1:0]     blk_r, v1blk_r, v2blk_r;
  logic [1:0]        level_r;
  logic [WAY_W-1:0]  tway_r, slot1_r, slot2_r;
  logic [RANK_W-1:0] trank_r, v1rank_r, v2rank_r;
  logic              ev1_r, ev2_r, v1dirty_r, bi_r;

  logic              out_valid_r, out_bi_r, out_vd_r;
  logic [1:0]        out_level_r;
  logic [11:0]       out_cycles_r;

  logic [1:0]  wl1, wl2;
  logic [3:0]  sl1, sl2;
  logic        clr_req, clearing, sw_start, sw_done, alloc, lvl_mem, out_free, acc_in;
  sw_cmd_t     cmd;
  sw_scan_t    scan;
  logic [LW-1:0] base;
  logic [BW-1:0] cblk, vic_blk;
  state_t      post_state, wb_next;

  function automatic logic [LW-1:0] base_of(logic [BW-1:0] b, logic [3:0] sl, logic [1:0] wl);
    logic [LW-1:0] m;
    m = (LW'(1) << sl) - LW'(1);
    return (LW'(b) & m) << wl;
  endfunction

  always_comb begin
    wl1 = l1_ways_r;
    if (5'(wl1) > 5'(MWL)) wl1 = 2'(MWL);
    if (5'(wl1) > 5'(L1CL)) wl1 = 2'(L1CL);
    sl1 = l1_sets_r;
    if (5'(sl1) > 5'(L1CL) - 5'(wl1)) sl1 = 4'(5'(L1CL) - 5'(wl1));
    wl2 = l2_ways_r;
    if (5'(wl2) > 5'(MWL)) wl2 = 2'(MWL);
    if (5'(wl2) > 5'(L2CL)) wl2 = 2'(L2CL);
    sl2 = l2_sets_r;
    if (5'(sl2) > 5'(L2CL) - 5'(wl2)) sl2 = 4'(5'(L2CL) - 5'(wl2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_en_r    <= 1'b1;
      l1_sets_r  <= 4'd5;
      l1_ways_r  <= 2'd2;
      l2_sets_r  <= 4'd8;
      l2_ways_r  <= 2'd3;
      l1_lat_r   <= 10'd1;
      l2_lat_r   <= 10'd10;
      mem_lat_r  <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRITE_ALLOCATE: wa_en_r    <= cfg_data[0];
        CFG_L1_SETS_LOG2:   l1_sets_r  <= cfg_data[3:0];
        CFG_L1_WAYS_LOG2:   l1_ways_r  <= cfg_data[1:0];
        CFG_L2_SETS_LOG2:   l2_sets_r  <= cfg_data[3:0];
        CFG_L2_WAYS_LOG2:   l2_ways_r  <= cfg_data[1:0];
        CFG_L1_LATENCY:     l1_lat_r   <= cfg_data;
        CFG_L2_LATENCY:     l2_lat_r   <= cfg_data;
        CFG_MEM_LATENCY:    mem_lat_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign clr_req = cfg_we && (cfg_index inside {CFG_L1_SETS_LOG2, CFG_L1_WAYS_LOG2,
                                                CFG_L2_SETS_LOG2, CFG_L2_WAYS_LOG2});

  assign in_stall = !(state_r == S_IDLE && !clearing && !clr_req);
  assign acc_in   = in_valid && !in_stall;
  assign alloc    = !wr_r || wa_en_r;
  assign lvl_mem  = (level_r == LVL_MEM);
  assign out_free = !out_valid_r || !out_stall;
  assign sw_start = !wait_r && state_r != S_IDLE && state_r != S_OUT;

  assign post_state = (ev1_r && v1dirty_r) ? S_WB_SCAN :
                      ((lvl_mem && ev2_r) ? S_BI_SCAN : S_OUT);
  assign wb_next    = (lvl_mem && ev2_r) ? S_BI_SCAN : S_OUT;

  always_comb begin
    cmd           = '0;
    cmd.mode      = SW_SCAN;
    cmd.ways_log2 = wl1;
    cblk          = blk_r;
    base          = base_of(blk_r, sl1, wl1);
    case (state_r)
      S_L1_TOUCH: begin
        cmd.mode = SW_TOUCH;
        cmd.way  = tway_r;
        cmd.rank = trank_r;
        cmd.flag = wr_r;
      end
      S_L1_DROP: begin
        cmd.mode = SW_DROP;
        cmd.way  = slot1_r;
        cmd.rank = v1rank_r;
      end
      S_L1_FILL: begin
        cmd.mode = SW_FILL;
        cmd.way  = slot1_r;
        cmd.flag = wr_r;
      end
      S_L2_SCAN, S_L2_TOUCH, S_L2_DROP, S_L2_FILL: begin
        cmd.l2        = 1'b1;
        cmd.ways_log2 = wl2;
        base          = base_of(blk_r, sl2, wl2);
        cmd.flag      = wr_r;
        if (state_r == S_L2_TOUCH) begin
          cmd.mode = SW_TOUCH;
          cmd.way  = tway_r;
          cmd.rank = trank_r;
        end else if (state_r == S_L2_DROP) begin
          cmd.mode = SW_DROP;
          cmd.way  = slot2_r;
          cmd.rank = v2rank_r;
        end else if (state_r == S_L2_FILL) begin
          cmd.mode = SW_FILL;
          cmd.way  = slot2_r;
        end
      end
      S_WB_SCAN, S_WB_TOUCH: begin
        cmd.l2        = 1'b1;
        cmd.ways_log2 = wl2;
        base          = base_of(v1blk_r, sl2, wl2);
        cblk          = v1blk_r;
        if (state_r == S_WB_TOUCH) begin
          cmd.mode = SW_TOUCH;
          cmd.way  = tway_r;
          cmd.rank = trank_r;
          cmd.flag = 1'b1;
        end
      end
      S_BI_SCAN, S_BI_DROP: begin
        base = base_of(v2blk_r, sl1, wl1);
        cblk = v2blk_r;
        if (state_r == S_BI_DROP) begin
          cmd.mode = SW_DROP;
          cmd.way  = tway_r;
          cmd.rank = trank_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc_in) state_nxt = S_L1_SCAN;
      end
      S_L1_SCAN: begin
        if (sw_done) state_nxt = scan.hit ? S_L1_TOUCH : S_L2_SCAN;
      end
      S_L1_TOUCH: begin
        if (sw_done) state_nxt = S_OUT;
      end
      S_L2_SCAN: begin
        if (sw_done) begin
          if (scan.hit) state_nxt = S_L2_TOUCH;
          else if (alloc) state_nxt = ev1_r ? S_L1_DROP : S_L1_FILL;
          else state_nxt = S_OUT;
        end
      end
      S_L2_TOUCH: begin
        if (sw_done) state_nxt = alloc ? (ev1_r ? S_L1_DROP : S_L1_FILL) : S_OUT;
      end
      S_L1_DROP: begin
        if (sw_done) state_nxt = S_L1_FILL;
      end
      S_L1_FILL: begin
        if (sw_done) state_nxt = lvl_mem ? (ev2_r ? S_L2_DROP : S_L2_FILL) : post_state;
      end
      S_L2_DROP: begin
        if (sw_done) state_nxt = S_L2_FILL;
      end
      S_L2_FILL: begin
        if (sw_done) state_nxt = post_state;
      end
      S_WB_SCAN: begin
        if (sw_done) state_nxt = scan.hit ? S_WB_TOUCH : wb_next;
      end
      S_WB_TOUCH: begin
        if (sw_done) state_nxt = wb_next;
      end
      S_BI_SCAN: begin
        if (sw_done) state_nxt = scan.hit ? S_BI_DROP : S_OUT;
      end
      S_BI_DROP: begin
        if (sw_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sw_start) wait_r <= 1'b1;
      else if (sw_done) wait_r <= 1'b0;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      wr_r    <= in_op;
      blk_r   <= in_address[AW-1:BLOCK_OFFSET_BITS];
      level_r <= LVL_L1;
      bi_r    <= 1'b0;
      ev1_r   <= 1'b0;
      ev2_r   <= 1'b0;
    end
    if (sw_done && scan.hit) begin
      tway_r  <= scan.hit_way;
      trank_r <= scan.hit_rank;
    end
    if (sw_done && state_r == S_L1_SCAN) begin
      slot1_r   <= scan.slot;
      ev1_r     <= scan.full && !scan.hit;
      v1blk_r   <= vic_blk;
      v1dirty_r <= scan.vic_dirty;
      v1rank_r  <= scan.vic_rank;
    end
    if (sw_done && state_r == S_L2_SCAN) begin
      slot2_r  <= scan.slot;
      ev2_r    <= scan.full && !scan.hit;
      v2blk_r  <= vic_blk;
      v2rank_r <= scan.vic_rank;
      level_r  <= scan.hit ? LVL_L2 : LVL_MEM;
    end
    if (sw_done && state_r == S_BI_SCAN && scan.hit) begin
      bi_r <= 1'b1;
    end
    if (state_r == S_OUT && out_free) begin
      out_level_r  <= level_r;
      out_cycles_r <= 12'(l1_lat_r)
                    + ((level_r != LVL_L1) ? 12'(l2_lat_r) : 12'd0)
                    + (lvl_mem ? 12'(mem_lat_r) : 12'd0);
      out_bi_r     <= bi_r;
      out_vd_r     <= (level_r != LVL_L1) && alloc && ev1_r && v1dirty_r;
    end
  end

  clru_sweep #(
    .BW       (BW),
    .L1_LINES (L1_LINES),
    .L2_LINES (L2_LINES)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (clr_req),
    .clearing  (clearing),
    .start     (sw_start),
    .cmd       (cmd),
    .base      (base),
    .blk       (cblk),
    .done      (sw_done),
    .scan      (scan),
    .vic_blk   (vic_blk)
  );

  assign out_valid            = out_valid_r;
  assign out_hit_level        = out_level_r;
  assign out_access_cycles    = out_cycles_r;
  assign out_back_invalidated = out_bi_r;
  assign out_l1_victim_dirty  = out_vd_r;

  `CLRU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `CLRU_ASSERT_IMP(a_backinv_only_on_mem, out_valid && out_back_invalidated, out_hit_level == LVL_MEM)
  `CLRU_ASSERT_IMP(a_l1_hit_no_victim, out_valid && out_hit_level == LVL_L1, !out_l1_victim_dirty && !out_back_invalidated)

endmodule

// ----- tb/sv/cache_scoreboard.sv -----
// Scoreboard class that predicts and checks results of the two-level inclusive cache.
class cache_scoreboard;
  localparam int L1N = 256;
  localparam int L2N = 4096;
  localparam int L2_OFF = L1N;

  typedef struct {
    logic [26:0] blk;
    bit          valid;
    bit          dirty;
    int          rank;
  } line_t;

  typedef struct {
    logic [1:0]  hit_level;
    logic [11:0] access_cycles;
    logic        back_invalidated;
    logic        l1_victim_dirty;
  } access_result_t;

  line_t          lines[L1N + L2N];
  access_result_t pending[$];
  bit             fill_on_wr;
  int             l1_sl, l1_wl, l2_sl, l2_wl, lat1, lat2, latm;
  int             errors;

  function new();
    clear_lines();
    fill_on_wr = 1; l1_sl = 5; l1_wl = 2; l2_sl = 8; l2_wl = 3;
    lat1 = 1; lat2 = 10; latm = 100;
    errors = 0;
  endfunction

  function void clear_lines();
    foreach (lines[i]) begin
      lines[i].valid = 0;
      lines[i].dirty = 0;
      lines[i].rank = 0;
      lines[i].blk = '0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [9:0] val);
    case (idx)
      clru_pkg::CFG_WRITE_ALLOCATE: fill_on_wr = val[0];
      clru_pkg::CFG_L1_SETS_LOG2: begin l1_sl = val[3:0]; clear_lines(); end
      clru_pkg::CFG_L1_WAYS_LOG2: begin l1_wl = val[1:0]; clear_lines(); end
      clru_pkg::CFG_L2_SETS_LOG2: begin l2_sl = val[3:0]; clear_lines(); end
      clru_pkg::CFG_L2_WAYS_LOG2: begin l2_wl = val[1:0]; clear_lines(); end
      clru_pkg::CFG_L1_LATENCY: lat1 = val;
      clru_pkg::CFG_L2_LATENCY: lat2 = val;
      clru_pkg::CFG_MEM_LATENCY: latm = val;
      default: begin
      end
    endcase
  endfunction

  function void geometry(int sl, int wl, int cap, output int sets, output int ways);
    ways = 1 << wl;
    sets = 1 << sl;
    while (ways > 1 && (ways > 8 || ways > cap)) ways = ways >> 1;
    while (sets > 1 && sets * ways > cap) sets = sets >> 1;
  endfunction

  function int set_base(int off, logic [26:0] blk, int sets, int ways);
    return off + int'(blk & 27'(sets - 1)) * ways;
  endfunction

  function int find_line(int base, int ways, logic [26:0] blk);
    for (int i = 0; i < ways; i++)
      if (lines[base + i].valid && lines[base + i].blk == blk) return base + i;
    return -1;
  endfunction

  function void touch(int base, int ways, int idx);
    int r;
    r = lines[idx].rank;
    for (int i = 0; i < ways; i++)
      if (lines[base + i].valid && base + i != idx && lines[base + i].rank < r)
        lines[base + i].rank++;
    lines[idx].rank = 0;
  endfunction

  function void drop(int base, int ways, int idx);
    int r;
    r = lines[idx].rank;
    lines[idx].valid = 0;
    for (int i = 0; i < ways; i++)
      if (lines[base + i].valid && lines[base + i].rank > r) lines[base + i].rank--;
  endfunction

  function bit fill(int off, int sets, int ways, logic [26:0] blk, bit dirty,
                    output line_t victim);
    int  base, slot;
    bit  evicted;
    base = set_base(off, blk, sets, ways);
    slot = ways;
    evicted = 0;
    victim = lines[base];
    for (int i = 0; i < ways; i++)
      if (!lines[base + i].valid) begin slot = i; break; end
    if (slot == ways) begin
      for (int i = 0; i < ways; i++)
        if (lines[base + i].rank == ways - 1) begin slot = i; break; end
      if (slot == ways) slot = 0;
      victim = lines[base + slot];
      evicted = 1;
      drop(base, ways, base + slot);
    end
    for (int i = 0; i < ways; i++)
      if (lines[base + i].valid) lines[base + i].rank++;
    lines[base + slot].blk = blk;
    lines[base + slot].valid = 1;
    lines[base + slot].dirty = dirty;
    lines[base + slot].rank = 0;
    return evicted;
  endfunction

  function void note_access(logic op, logic [31:0] address);
    logic [26:0]    blk;
    int             s1, w1, s2, w2, b1, b2, idx, j, vb, cycles;
    bit             alloc, ev1, ev2;
    line_t          v1, v2;
    access_result_t res;
    blk = address[31:5];
    geometry(l1_sl, l1_wl, L1N, s1, w1);
    geometry(l2_sl, l2_wl, L2N, s2, w2);
    b1 = set_base(0, blk, s1, w1);
    b2 = set_base(L2_OFF, blk, s2, w2);
    cycles = lat1;
    res.back_invalidated = 0;
    res.l1_victim_dirty = 0;
    ev1 = 0;
    ev2 = 0;
    idx = find_line(b1, w1, blk);
    if (idx >= 0) begin
      res.hit_level = clru_pkg::LVL_L1;
      if (op) lines[idx].dirty = 1;
      touch(b1, w1, idx);
    end else begin
      alloc = !op || fill_on_wr;
      cycles += lat2;
      idx = find_line(b2, w2, blk);
      if (idx >= 0) begin
        res.hit_level = clru_pkg::LVL_L2;
        if (op) lines[idx].dirty = 1;
        touch(b2, w2, idx);
        if (alloc) ev1 = fill(0, s1, w1, blk, op, v1);
      end else begin
        res.hit_level = clru_pkg::LVL_MEM;
        cycles += latm;
        if (alloc) begin
          ev1 = fill(0, s1, w1, blk, op, v1);
          ev2 = fill(L2_OFF, s2, w2, blk, op, v2);
        end
      end
      if (ev1 && v1.dirty) begin
        vb = set_base(L2_OFF, v1.blk, s2, w2);
        j = find_line(vb, w2, v1.blk);
        res.l1_victim_dirty = 1;
        if (j >= 0) begin
          lines[j].dirty = 1;
          touch(vb, w2, j);
        end
      end
      if (ev2) begin
        vb = set_base(0, v2.blk, s1, w1);
        j = find_line(vb, w1, v2.blk);
        if (j >= 0) begin
          drop(vb, w1, j);
          res.back_invalidated = 1;
        end
      end
    end
    res.access_cycles = 12'(cycles);
    pending = {pending, res};
  endfunction

  function void check_result(logic [1:0] lvl, logic [11:0] cyc, logic binv, logic vdirty);
    access_result_t exp_res;
    if (pending.size() == 0) begin
      $error("result arrived with no access outstanding");
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    if (lvl !== exp_res.hit_level) begin
      $error("hit_level expected %0d actual %0d", exp_res.hit_level, lvl);
      errors++;
    end
    if (cyc !== exp_res.access_cycles) begin
      $error("access_cycles expected %0d actual %0d", exp_res.access_cycles, cyc);
      errors++;
    end
    if (binv !== exp_res.back_invalidated) begin
      $error("back_invalidated expected %0d actual %0d", exp_res.back_invalidated, binv);
      errors++;
    end
    if (vdirty !== exp_res.l1_victim_dirty) begin
      $error("l1_victim_dirty expected %0d actual %0d", exp_res.l1_victim_dirty, vdirty);
      errors++;
    end
  endfunction
endclass

// ----- tb/sv/tb_top.sv -----
// Top-level testbench of the two-level inclusive cache: stimulus, idling and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import clru_pkg::*;

  localparam int LIMIT = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_op = 0;
  logic [31:0] in_address = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_hit_level;
  logic [11:0] out_access_cycles;
  logic        out_back_invalidated;
  logic        out_l1_victim_dirty;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  cache_scoreboard sb = new();
  int          send_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;
  int          cycle_count = 0;
  int          stride = 1;
  logic [18:0] tags[4];

  two_level_inclusive_cache_lru DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_hit_level, out_access_cycles, out_back_invalidated,
                      out_l1_victim_dirty);
  end

  task automatic send_access(logic op, logic [31:0] address);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_address <= address;
    forever begin
      @(negedge clk);
      if (!in_stall) begin
        sb.note_access(op, address);
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic setup(bit wa, int s1, int w1, int s2, int w2, int a, int b, int c);
    wait_drained();
    write_reg(CFG_WRITE_ALLOCATE, 10'(wa));
    write_reg(CFG_L1_SETS_LOG2, 10'(s1));
    write_reg(CFG_L1_WAYS_LOG2, 10'(w1));
    write_reg(CFG_L2_SETS_LOG2, 10'(s2));
    write_reg(CFG_L2_WAYS_LOG2, 10'(w2));
    write_reg(CFG_L1_LATENCY, 10'(a));
    write_reg(CFG_L2_LATENCY, 10'(b));
    write_reg(CFG_MEM_LATENCY, 10'(c));
    cfg_we <= 0;
    foreach (tags[i]) tags[i] = 19'($urandom);
  endtask

  task automatic run_random(int n, int spct, int rpct, bit pressure);
    logic [31:0] address;
    send_pct = spct;
    stall_pct = rpct;
    if (pressure) hold_off = 400;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        address = $urandom;
      end else begin
        address = {tags[$urandom_range(0, 3)], 8'($urandom_range(0, 7) * stride), 5'd0};
        address[4:0] = 5'($urandom);
      end
      send_access(1'($urandom), address);
      if (pressure && i == n / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_access(0, 32'h0000_0000);
    send_access(0, 32'h0000_001F);
    send_access(1, 32'h0000_0004);
    for (int i = 1; i <= 4; i++) send_access(0, 32'(i * 32 * 32));
    send_access(0, 32'h0000_0000);
    send_access(1, 32'hFFFF_FFFF);
    send_access(0, 32'hFFFF_FFE0);
    for (int i = 1; i <= 9; i++) send_access(i[0], 32'(i * 256 * 32));
    send_access(0, 32'h0000_2000);

    stride = 1;
    setup(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(60, 65, 0, 0);
    setup(1, 0, 2, 0, 0, 3, 5, 7);
    run_random(80, 0, 0, 0);
    stride = 32;
    setup(1, 8, 3, 12, 3, 1023, 1023, 1023);
    run_random(120, 0, 65, 0);
    stride = 1;
    setup(1, 1, 1, 2, 1, $urandom_range(0, 1023), $urandom_range(0, 1023),
          $urandom_range(0, 1023));
    run_random(160, 22, 22, 1);
    stride = 4;
    setup(0, 2, 2, 3, 2, 1, 10, 100);
    run_random(160, 65, 0, 0);
    setup(1, 3, 3, 4, 3, $urandom_range(0, 1023), $urandom_range(0, 1023),
          $urandom_range(0, 1023));
    run_random(200, 0, 0, 0);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- two_level_inclusive_cache_lru.f -----
+incdir+src
src/clru_pkg.sv
src/clru_sweep.sv
src/two_level_inclusive_cache_lru.sv
tb/sv/cache_scoreboard.sv
tb/sv/tb_top.sv
